FILE: rtl/core/bppg_pkg.sv
// ----------------------------------------------------------------------------
// bppg_pkg
// Shared types, constants and helper functions of the background pattern
// pixel generator.
// ----------------------------------------------------------------------------
package bppg_pkg;

  localparam int COORD_BITS = 12;
  localparam int CB         = 13;
  localparam int DW         = ((COORD_BITS > CB) ? COORD_BITS : CB) + 1;
  localparam int SQB        = 2 * DW - 2;
  localparam int DB         = SQB + 1;
  localparam int R2B        = 2 * CB;
  localparam int FNB        = R2B + 8;
  localparam int FB         = 9;
  localparam int GN         = COORD_BITS + 8;
  localparam int HB         = CB;
  localparam int PADDR_BITS = 5;

  localparam int DIV0    = 4;
  localparam int NSTAGES = DIV0 + GN + 5;
  localparam int ST_FSQ  = DIV0 + GN;
  localparam int ST_WGT  = ST_FSQ + 1;
  localparam int ST_MUL  = ST_FSQ + 2;
  localparam int ST_DIV  = ST_FSQ + 3;

  localparam logic [23:0] COL_SOLID     = 24'h0C0C12;
  localparam logic [23:0] COL_GRID_LINE = 24'h1C1822;
  localparam logic [23:0] COL_GRID_BG   = 24'h121018;
  localparam logic [23:0] COL_BASE      = 24'h0A0A12;

  localparam int GRID_STEP    = 40;
  localparam int GRAD_WEIGHT  = 180;
  localparam int GLOW1_WEIGHT = 180;
  localparam int GLOW2_WEIGHT = 150;
  localparam int C1X_PCT      = 72;
  localparam int C1Y_PCT      = 20;
  localparam int C2X_PCT      = 22;
  localparam int C2Y_PCT      = 82;
  localparam int RADIUS_PCT   = 58;

  localparam int GRID_SH = COORD_BITS + 6;
  localparam int GRID_K  = ((1 << GRID_SH) + GRID_STEP - 1) / GRID_STEP;
  localparam int GPB     = 2 * COORD_BITS + 2;
  localparam int GCB     = COORD_BITS + 6;

  localparam int PCT_SH = 27;
  localparam int PCT_K  = ((1 << PCT_SH) + 99) / 100;
  localparam longint DIV255_K = ((64'd1 << 32) + 64'd254) / 64'd255;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_GLOW1  = 3'd1;
  localparam logic [2:0] REG_GLOW2  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  localparam logic [1:0] HOLD_CYCLES = 2'd3;

  typedef enum logic [1:0] {
    MODE_AURORA   = 2'd0,
    MODE_GRADIENT = 2'd1,
    MODE_GRID     = 2'd2,
    MODE_SOLID    = 2'd3
  } mode_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    mode_t        mode;
    logic [23:0]  glow1;
    logic [23:0]  glow2;
    logic [CB-1:0] width;
    logic [CB-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [CB-1:0]  c1x;
    logic [CB-1:0]  c1y;
    logic [CB-1:0]  c2x;
    logic [CB-1:0]  c2y;
    logic [R2B-1:0] r2;
    logic [HB-1:0]  hh;
  } derived_t;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic signed [DW-1:0]  dx1;
    logic signed [DW-1:0]  dy1;
    logic signed [DW-1:0]  dx2;
    logic signed [DW-1:0]  dy2;
    coord_t                qx;
    coord_t                qy;
    logic [GN-1:0]         gnum;
    logic [SQB-1:0]        s1x;
    logic [SQB-1:0]        s1y;
    logic [SQB-1:0]        s2x;
    logic [SQB-1:0]        s2y;
    logic                  grid;
    logic                  in1;
    logic                  in2;
    logic [FNB-1:0]        rem1;
    logic [FNB-1:0]        rem2;
    logic [FB-1:0]         f1;
    logic [FB-1:0]         f2;
    logic [HB:0]           grem;
    logic [GN-1:0]         gq;
    logic [FB-1:0]         ff1;
    logic [FB-1:0]         ff2;
    logic [15:0]           wa;
    logic [7:0]            wb;
    logic [2:0][23:0]      pa;
    logic [2:0][15:0]      pb;
    logic [2:0][15:0]      qa;
    logic [2:0][7:0]       qb;
    logic [23:0]           color;
  } stage_t;

  function automatic logic [15:0] div255(input logic [23:0] v);
    logic [56:0] p;
    p = 57'(v) * 57'(DIV255_K);
    return p[47:32];
  endfunction

  function automatic logic [CB-1:0] div100(input logic [19:0] v);
    logic [40:0] p;
    p = 41'(v) * 41'(PCT_K);
    return p[PCT_SH+CB-1:PCT_SH];
  endfunction

endpackage

FILE: rtl/core/bppg_if.sv
// ----------------------------------------------------------------------------
// bppg_if
// Valid/ready channels for pixel coordinates in and pixel colours out.
// ----------------------------------------------------------------------------
interface bppg_in_if import bppg_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bppg_out_if import bppg_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;

  modport source (output valid, output pixel_color, input ready);
  modport sink   (input valid, input pixel_color, output ready);
endinterface

FILE: rtl/core/bppg_cfg.sv
// ----------------------------------------------------------------------------
// bppg_cfg
// APB register file and the frame geometry derived from it.
// ----------------------------------------------------------------------------
module bppg_cfg import bppg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg,
  output derived_t              drv,
  output logic                  settled
);

  logic       wr;
  logic [2:0] idx;
  logic [1:0] hold;

  logic [19:0]   pw72, pw22, pw58, ph20, ph82;
  logic [HB-1:0] hh_a;
  derived_t      drv_b;

  assign idx     = paddr[PADDR_BITS-1:2];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign settled = (hold == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_AURORA;
      cfg.glow1  <= '0;
      cfg.glow2  <= '0;
      cfg.width  <= CB'(1024);
      cfg.height <= CB'(768);
      hold       <= HOLD_CYCLES;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   cfg.mode   <= mode_t'(pwdata[1:0]);
        REG_GLOW1:  cfg.glow1  <= pwdata[23:0];
        REG_GLOW2:  cfg.glow2  <= pwdata[23:0];
        REG_WIDTH:  cfg.width  <= pwdata[CB-1:0];
        REG_HEIGHT: cfg.height <= pwdata[CB-1:0];
        default: ;
      endcase
      hold <= HOLD_CYCLES;
    end else if (hold != 2'd0) begin
      hold <= hold - 2'd1;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = 32'(cfg.mode);
      REG_GLOW1:  prdata = 32'(cfg.glow1);
      REG_GLOW2:  prdata = 32'(cfg.glow2);
      REG_WIDTH:  prdata = 32'(cfg.width);
      REG_HEIGHT: prdata = 32'(cfg.height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    pw72 <= 20'(cfg.width)  * 20'(C1X_PCT);
    pw22 <= 20'(cfg.width)  * 20'(C2X_PCT);
    pw58 <= 20'(cfg.width)  * 20'(RADIUS_PCT);
    ph20 <= 20'(cfg.height) * 20'(C1Y_PCT);
    ph82 <= 20'(cfg.height) * 20'(C2Y_PCT);
    hh_a <= (cfg.height == '0) ? HB'(1) : cfg.height;

    drv_b.c1x <= div100(pw72);
    drv_b.c1y <= div100(ph20);
    drv_b.c2x <= div100(pw22);
    drv_b.c2y <= div100(ph82);
    drv_b.hh  <= hh_a;
    drv_b.r2  <= R2B'(div100(pw58));

    drv.c1x <= drv_b.c1x;
    drv.c1y <= drv_b.c1y;
    drv.c2x <= drv_b.c2x;
    drv.c2y <= drv_b.c2y;
    drv.hh  <= drv_b.hh;
    drv.r2  <= drv_b.r2 * drv_b.r2;
  end

endmodule

FILE: rtl/core/background_pattern_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// background_pattern_pixel_generator_top
// Colours one pixel coordinate per word from the selected background pattern.
// ----------------------------------------------------------------------------
// One coordinate word is taken per clock unless back-pressure or a geometry
// recompute holds the input off; each colour word leaves the last stage.
// The depth is set by the gradient divider, which resolves one quotient bit
// per stage over COORD_BITS + 8 stages; the aurora falloff divider shares the
// last nine of them. Every stage has its own valid bit and stalls only when
// it holds a word and the stage ahead is stalled, so bubbles close up under
// back-pressure. After reset and after every register write the input holds
// off until the hold counter runs out while glow centres and radius recompute.
module background_pattern_pixel_generator_top import bppg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  bppg_in_if.sink               pix_in,
  bppg_out_if.source            pix_out
);

  cfg_t     cfg;
  derived_t drv;
  logic     settled;

  stage_t pipe [NSTAGES];
  stage_t nxt  [NSTAGES];
  logic   vld  [NSTAGES];
  logic   en   [NSTAGES];
  logic   aurora;

  bppg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .drv     (drv),
    .settled (settled)
  );

  assign aurora = (cfg.mode == MODE_AURORA);

  always_comb begin
    en[NSTAGES-1] = !vld[NSTAGES-1] || pix_out.ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign pix_in.ready        = en[0] && settled;
  assign pix_out.valid       = vld[NSTAGES-1];
  assign pix_out.pixel_color = pipe[NSTAGES-1].color;

  always_comb begin
    stage_t                s;
    logic signed [2*DW-1:0] sq_a, sq_b, sq_c, sq_d;
    logic [DB-1:0]         d1, d2;
    logic [HB:0]           gt;
    logic [FNB-1:0]        dv;
    logic [17:0]           fsq1, fsq2;
    logic [16:0]           wt1, wt2;
    logic [16:0]           sa, sb;
    logic [7:0]            cha, chb;
    logic [23:0]           blend;
    logic [23:0]           glow_a;

    sq_a   = '0;
    sq_b   = '0;
    sq_c   = '0;
    sq_d   = '0;
    d1     = '0;
    d2     = '0;
    gt     = '0;
    dv     = '0;
    fsq1   = '0;
    fsq2   = '0;
    wt1    = '0;
    wt2    = '0;
    sa     = '0;
    sb     = '0;
    cha    = '0;
    chb    = '0;
    blend  = '0;
    glow_a = '0;

    nxt[0]   = pipe[0];
    nxt[0].x = pix_in.pixel_x;
    nxt[0].y = pix_in.pixel_y;

    for (int i = 1; i < NSTAGES; i++) begin
      s = pipe[i-1];
      if (i == 1) begin
        s.dx1  = DW'(s.x) - DW'(drv.c1x);
        s.dy1  = DW'(s.y) - DW'(drv.c1y);
        s.dx2  = DW'(s.x) - DW'(drv.c2x);
        s.dy2  = DW'(s.y) - DW'(drv.c2y);
        s.qx   = COORD_BITS'((GPB'(s.x) * GPB'(GRID_K)) >> GRID_SH);
        s.qy   = COORD_BITS'((GPB'(s.y) * GPB'(GRID_K)) >> GRID_SH);
        s.gnum = GN'(s.y) * GN'(GRAD_WEIGHT);
      end else if (i == 2) begin
        sq_a  = s.dx1 * s.dx1;
        sq_b  = s.dy1 * s.dy1;
        sq_c  = s.dx2 * s.dx2;
        sq_d  = s.dy2 * s.dy2;
        s.s1x = sq_a[SQB-1:0];
        s.s1y = sq_b[SQB-1:0];
        s.s2x = sq_c[SQB-1:0];
        s.s2y = sq_d[SQB-1:0];
        s.grid = (GCB'(s.x) == GCB'(s.qx) * GCB'(GRID_STEP)) ||
                 (GCB'(s.y) == GCB'(s.qy) * GCB'(GRID_STEP));
      end else if (i == 3) begin
        d1     = DB'(s.s1x) + DB'(s.s1y);
        d2     = DB'(s.s2x) + DB'(s.s2y);
        s.in1  = d1 < DB'(drv.r2);
        s.in2  = d2 < DB'(drv.r2);
        s.rem1 = s.in1 ? ((FNB'(drv.r2) - FNB'(d1)) << 8) : '0;
        s.rem2 = s.in2 ? ((FNB'(drv.r2) - FNB'(d2)) << 8) : '0;
        s.f1   = '0;
        s.f2   = '0;
        s.grem = '0;
        s.gq   = '0;
      end else if (i >= DIV0 && i < ST_FSQ) begin
        gt = {s.grem[HB-1:0], s.gnum[GN-1-(i-DIV0)]};
        if (gt >= (HB+1)'(drv.hh)) begin
          s.grem = gt - (HB+1)'(drv.hh);
          s.gq[GN-1-(i-DIV0)] = 1'b1;
        end else begin
          s.grem = gt;
        end
        if (GN - 1 - (i - DIV0) < FB) begin
          dv = FNB'(drv.r2) << (GN - 1 - (i - DIV0));
          if (s.rem1 >= dv) begin
            s.rem1 = s.rem1 - dv;
            s.f1[(GN-1-(i-DIV0)) % FB] = 1'b1;
          end
          if (s.rem2 >= dv) begin
            s.rem2 = s.rem2 - dv;
            s.f2[(GN-1-(i-DIV0)) % FB] = 1'b1;
          end
        end
      end else if (i == ST_FSQ) begin
        fsq1  = 18'(s.f1) * 18'(s.f1);
        fsq2  = 18'(s.f2) * 18'(s.f2);
        s.ff1 = fsq1[FB+7:8];
        s.ff2 = fsq2[FB+7:8];
      end else if (i == ST_WGT) begin
        wt1 = 17'(s.ff1) * 17'(GLOW1_WEIGHT);
        wt2 = 17'(s.ff2) * 17'(GLOW2_WEIGHT);
        if (aurora) begin
          s.wa = s.in1 ? 16'(wt1[16:8]) : '0;
        end else begin
          s.wa = (s.gq > GN'(16'hFFFF)) ? 16'hFFFF : s.gq[15:0];
        end
        s.wb = (aurora && s.in2) ? wt2[15:8] : '0;
      end else if (i == ST_MUL) begin
        glow_a = aurora ? cfg.glow1 : cfg.glow2;
        for (int c = 0; c < 3; c++) begin
          s.pa[c] = 24'(glow_a[c*8 +: 8]) * 24'(s.wa);
          s.pb[c] = 16'(cfg.glow2[c*8 +: 8]) * 16'(s.wb);
        end
      end else if (i == ST_DIV) begin
        for (int c = 0; c < 3; c++) begin
          s.qa[c] = div255(s.pa[c]);
          s.qb[c] = 8'(div255(24'(s.pb[c])));
        end
      end else begin
        blend = '0;
        for (int c = 0; c < 3; c++) begin
          sa  = 17'(COL_BASE[c*8 +: 8]) + 17'(s.qa[c]);
          cha = (sa > 17'd255) ? 8'hFF : sa[7:0];
          sb  = 17'(cha) + 17'(s.qb[c]);
          chb = (sb > 17'd255) ? 8'hFF : sb[7:0];
          blend[c*8 +: 8] = chb;
        end
        case (cfg.mode)
          MODE_SOLID: s.color = COL_SOLID;
          MODE_GRID:  s.color = s.grid ? COL_GRID_LINE : COL_GRID_BG;
          default:    s.color = blend;
        endcase
      end
      nxt[i] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld[0] <= pix_in.valid && pix_in.ready;
      end
      for (int i = 1; i < NSTAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTAGES; i++) begin
      if (en[i]) begin
        pipe[i] <= nxt[i];
      end
    end
  end

endmodule

FILE: rtl/core/bppg_checker.sv
// ----------------------------------------------------------------------------
// bppg_checker
// Port-level checks of the background pattern pixel generator.
// ----------------------------------------------------------------------------
module bppg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] pixel_color,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_color))
    else $error("colour word dropped or changed under stall");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !in_ready)
    else $error("input taken while geometry recomputes");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("colour word present straight after reset");

endmodule

bind background_pattern_pixel_generator_top bppg_checker u_bppg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .pixel_color (pix_out.pixel_color),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite)
);
